// File: hw/rtl/r2fft_pkg.sv
// Shared constants, types and the twiddle ROM of the radix-2 FFT core.
// Depends on nothing; the interfaces and the core take it by scoped names.
`default_nettype none
package r2fft_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int LG_MAX      = $clog2(MAX_POINTS);
  localparam int HALF_POINTS = MAX_POINTS / 2;
  localparam int ADDR_W      = LG_MAX;
  localparam int TW_IDX_W    = LG_MAX - 1;
  localparam int TW_BITS     = 16;
  localparam int TW_FRAC     = TW_BITS - 1;
  localparam int WORK_W      = 27;
  localparam int SAMPLE_W    = 16;
  localparam int LG_W        = 4;
  localparam int PROD_W      = WORK_W + TW_BITS;
  localparam int ACC_W       = PROD_W + 1;
  localparam int TWP_W       = ACC_W - TW_FRAC;

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;

  localparam logic [LG_W-1:0] LG_RESET = LG_W'(10);
  localparam logic [LG_W-1:0] LG_MIN   = LG_W'(2);

  // Taylor series divisors: (2n+1)(2n+2) for cosine, (2n+2)(2n+3) for sine
  typedef longint div_tab_t [14];
  localparam div_tab_t COS_DIV = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552,
                                   650, 756};
  localparam div_tab_t SIN_DIV = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600,
                                   702, 812};

  typedef logic [2*TW_BITS-1:0] tw_rom_t [HALF_POINTS];

  function automatic longint series_q30(input longint x, input longint first,
                                        input bit is_sin);
    longint term;
    longint sum;
    term = first;
    sum  = 0;
    for (int n = 0; n < 14; n++) begin
      sum  = (n % 2 == 1) ? sum - term : sum + term;
      term = (term * x) >>> 30;
      term = (term * x) >>> 30;
      term = is_sin ? term / SIN_DIV[n] : term / COS_DIV[n];
    end
    return (sum < 0) ? 64'sd0 : sum;
  endfunction

  function automatic longint to_twiddle(input longint v);
    longint r;
    longint cap;
    r   = (v + (64'sd1 <<< (29 - TW_FRAC))) >>> (30 - TW_FRAC);
    cap = (64'sd1 <<< TW_FRAC) - 1;
    return (r > cap) ? cap : r;
  endfunction

  // Entry m holds {cos, -sin} of 2*pi*m/MAX_POINTS in Q1.15
  function automatic tw_rom_t build_twiddles();
    tw_rom_t rom;
    longint  mm;
    longint  x;
    longint  c;
    longint  s;
    bit      neg;
    for (int m = 0; m < HALF_POINTS; m++) begin
      neg = (4 * m > MAX_POINTS);
      mm  = neg ? longint'(HALF_POINTS - m) : longint'(m);
      x   = (2 * PI_Q30 * mm + HALF_POINTS) >>> LG_MAX;
      c   = to_twiddle(series_q30(x, ONE_Q30, 1'b0));
      s   = to_twiddle(series_q30(x, x, 1'b1));
      c   = neg ? -c : c;
      s   = -s;
      rom[m] = {c[TW_BITS-1:0], s[TW_BITS-1:0]};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_twiddles();

endpackage
`default_nettype wire

// File: hw/rtl/r2fft_in_if.sv
// Request channel of the FFT core: load a sample or read a bin.
// Depends on r2fft_pkg for field widths.
`default_nettype none
interface r2fft_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample;
  logic [r2fft_pkg::ADDR_W-1:0]        bin_index;

  modport source (output valid, action, sample, bin_index, input ready);
  modport sink   (input valid, action, sample, bin_index, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/r2fft_out_if.sv
// Result channel of the FFT core: one complex bin per read request.
// Depends on r2fft_pkg for field widths.
`default_nettype none
interface r2fft_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [r2fft_pkg::WORK_W-1:0] bin_real;
  logic signed [r2fft_pkg::WORK_W-1:0] bin_imag;
  logic                                result_ready;

  modport source (output valid, bin_real, bin_imag, result_ready, input ready);
  modport sink   (input valid, bin_real, bin_imag, result_ready, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/radix2_fft_real_input_core.sv
// Radix-2 in-place DIT FFT core: work memory, one shared multiplier, sequencer.
// Depends on r2fft_pkg, r2fft_in_if and r2fft_out_if.
// A load request writes its sample into the work memory; a read request passes its bin
// via the read and output registers. The frame's last load starts (N/2)*log2(N)
// butterflies, no multiply when the twiddle is one; no request is taken meanwhile.
// Reset clears control and sets log2_points to 10; the work memory is undefined.
`default_nettype none
module radix2_fft_real_input_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [r2fft_pkg::LG_W-1:0]   cfg_wdata_i,
  r2fft_in_if.sink                          req_i,
  r2fft_out_if.source                       rsp_o
);

  localparam int AW  = r2fft_pkg::ADDR_W;
  localparam int TW  = r2fft_pkg::TW_IDX_W;
  localparam int WW  = r2fft_pkg::WORK_W;
  localparam int PW  = r2fft_pkg::PROD_W;
  localparam int CW  = r2fft_pkg::ACC_W;
  localparam int RW  = r2fft_pkg::TWP_W;
  localparam int BW  = r2fft_pkg::TW_BITS;
  localparam int LW  = r2fft_pkg::LG_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BIN  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WP   = 3'd4;
  localparam logic [2:0] S_WQ   = 3'd5;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  logic [2:0]  state_q, state_d;
  logic [LW-1:0] lg_q;
  logic [AW-1:0] cnt_q;
  logic        done_q;
  logic [LW-1:0] stg_q;
  logic [TW-1:0] bfly_q;
  logic [2:0]  ms_q;
  logic        tzero_q;
  logic        out_valid_q;
  logic signed [WW-1:0] out_re_q, out_im_q;
  logic        out_rdy_q;

  logic signed [WW-1:0] mem_re [r2fft_pkg::MAX_POINTS];
  logic signed [WW-1:0] mem_im [r2fft_pkg::MAX_POINTS];
  logic signed [WW-1:0] pr_q, pi_q, xr_q, xi_q;
  logic signed [BW-1:0] wr_q, wi_q;
  logic signed [PW-1:0] prod_q;
  logic signed [CW-1:0] acc_q;
  logic signed [RW-1:0] tr_q, ti_q;

  logic [LW-1:0] nlg;
  logic [AW-1:0] nmask;
  logic [TW-1:0] hmask, tidx, kidx;
  logic [AW-1:0] addr_p, addr_q, half10;
  logic          accept, rd_en, last_bfly;
  logic [AW-1:0] rd_a, rd_b;
  logic          we;
  logic [AW-1:0] waddr;
  logic signed [WW-1:0] wre, wim;
  logic signed [WW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [RW-1:0] tr_use, ti_use;

  function automatic logic signed [WW-1:0] sat_work(input logic signed [RW:0] v);
    logic signed [RW:0] hi;
    logic signed [RW:0] lo;
    hi = (RW+1)'((64'sd1 <<< (WW-1)) - 1);
    lo = -(RW+1)'(64'sd1 <<< (WW-1));
    if (v > hi) begin
      return hi[WW-1:0];
    end else if (v < lo) begin
      return lo[WW-1:0];
    end
    return v[WW-1:0];
  endfunction

  // Round to nearest, ties toward plus infinity
  function automatic logic signed [RW-1:0] round_tw(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] u;
    u = v + CW'(64'sd1 <<< (r2fft_pkg::TW_FRAC - 1));
    return u[CW-1:r2fft_pkg::TW_FRAC];
  endfunction

  // Effective size
  always_comb begin
    if (lg_q < r2fft_pkg::LG_MIN) begin
      nlg = r2fft_pkg::LG_MIN;
    end else if (lg_q > LW'(r2fft_pkg::LG_MAX)) begin
      nlg = LW'(r2fft_pkg::LG_MAX);
    end else begin
      nlg = lg_q;
    end
  end
  assign nmask = AW'((AW+1)'(1) << nlg) - AW'(1);

  // Butterfly addressing
  assign hmask     = TW'((TW'(1) << (stg_q - LW'(1))) - TW'(1));
  assign half10    = AW'(1) << (stg_q - LW'(1));
  assign tidx      = bfly_q & hmask;
  assign addr_p    = {bfly_q & ~hmask, 1'b0} | {1'b0, tidx};
  assign addr_q    = addr_p | half10;
  assign kidx      = TW'(tidx << (LW'(r2fft_pkg::LG_MAX) - stg_q));
  assign last_bfly = (bfly_q == nmask[AW-1:1]);

  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign rd_en = (state_q == S_RD) || (accept && (req_i.action == ACT_READ));
  assign rd_a  = (state_q == S_RD) ? addr_p : (req_i.bin_index & nmask);
  assign rd_b  = addr_q;

  assign tr_use = tzero_q ? RW'(xr_q) : tr_q;
  assign ti_use = tzero_q ? RW'(xi_q) : ti_q;

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q & nmask;
    wre   = WW'(req_i.sample);
    wim   = '0;
    unique case (state_q)
      S_IDLE: begin
        we = accept && (req_i.action == ACT_LOAD);
      end
      S_WP: begin
        we    = 1'b1;
        waddr = addr_p;
        wre   = sat_work((RW+1)'(pr_q) + (RW+1)'(tr_use));
        wim   = sat_work((RW+1)'(pi_q) + (RW+1)'(ti_use));
      end
      S_WQ: begin
        we    = 1'b1;
        waddr = addr_q;
        wre   = sat_work((RW+1)'(pr_q) - (RW+1)'(tr_use));
        wim   = sat_work((RW+1)'(pi_q) - (RW+1)'(ti_use));
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_re[waddr] <= wre;
      mem_im[waddr] <= wim;
    end
    if (rd_en) begin
      pr_q <= mem_re[rd_a];
      pi_q <= mem_im[rd_a];
      xr_q <= mem_re[rd_b];
      xi_q <= mem_im[rd_b];
      {wr_q, wi_q} <= r2fft_pkg::TW_ROM[kidx];
    end
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (ms_q[1:0])
      2'd0: begin mul_a = xr_q; mul_b = wr_q; end
      2'd1: begin mul_a = xi_q; mul_b = wi_q; end
      2'd2: begin mul_a = xr_q; mul_b = wi_q; end
      default: begin mul_a = xi_q; mul_b = wr_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      prod_q <= mul_a * mul_b;
      unique case (ms_q)
        3'd1, 3'd3: acc_q <= CW'(prod_q);
        3'd2: tr_q <= round_tw(acc_q - CW'(prod_q));
        3'd4: ti_q <= round_tw(acc_q + CW'(prod_q));
        default: acc_q <= acc_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.action == ACT_READ) begin
            state_d = S_BIN;
          end else if ((cnt_q & nmask) == nmask) begin
            state_d = S_RD;
          end
        end
      end
      S_BIN:  state_d = S_IDLE;
      S_RD:   state_d = (tidx == '0) ? S_WP : S_MUL;
      S_MUL:  state_d = (ms_q == 3'd4) ? S_WP : S_MUL;
      S_WP:   state_d = S_WQ;
      S_WQ:   state_d = (last_bfly && stg_q == nlg) ? S_IDLE : S_RD;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lg_q        <= r2fft_pkg::LG_RESET;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      stg_q       <= LW'(1);
      bfly_q      <= '0;
      ms_q        <= '0;
      tzero_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_rdy_q   <= 1'b0;
      out_re_q    <= '0;
      out_im_q    <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q != S_BIN) && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        lg_q   <= cfg_wdata_i;
        cnt_q  <= '0;
        done_q <= 1'b0;
      end else if (accept && (req_i.action == ACT_LOAD)) begin
        done_q <= 1'b0;
        if ((cnt_q & nmask) == nmask) begin
          cnt_q  <= '0;
          stg_q  <= LW'(1);
          bfly_q <= '0;
        end else begin
          cnt_q <= (cnt_q & nmask) + AW'(1);
        end
      end
      unique case (state_q)
        S_BIN: begin
          out_valid_q <= 1'b1;
          out_rdy_q   <= done_q;
          out_re_q    <= done_q ? pr_q : '0;
          out_im_q    <= done_q ? pi_q : '0;
        end
        S_RD: begin
          tzero_q <= (tidx == '0);
          ms_q    <= '0;
        end
        S_MUL: begin
          ms_q <= ms_q + 3'd1;
        end
        S_WQ: begin
          // advance to the next butterfly or the next stage, or flag done after the last
          if (last_bfly) begin
            bfly_q <= '0;
            if (stg_q == nlg) begin
              if (!cfg_we_i) begin
                done_q <= 1'b1;
              end
            end else begin
              stg_q <= stg_q + LW'(1);
            end
          end else begin
            bfly_q <= bfly_q + TW'(1);
          end
        end
        default: begin
          ms_q <= ms_q;
        end
      endcase
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.bin_real     = out_re_q;
  assign rsp_o.bin_imag     = out_im_q;
  assign rsp_o.result_ready = out_rdy_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !req_i.ready)
    else $error("request taken while transform busy");

  a_done_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> ($past(state_q) == S_WQ))
    else $error("done set outside last butterfly write");

  a_out_from_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_BIN))
    else $error("result appeared without read");

  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (stg_q >= LW'(1) && stg_q <= nlg))
    else $error("stage counter out of range");

endmodule
`default_nettype wire
